>>> design/ffsa_pkg.sv
`timescale 1ns / 1ps

package ffsa_pkg;

    // Widths of the fields on the ports.
    localparam int ADDR_W    = 21;
    localparam int HDR_W     = 7;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN_ADDR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ARENA_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [ADDR_W-1:0] ARENA_LIMIT_RST  = 21'd1048576;
    localparam logic [HDR_W-1:0]  HEADER_BYTES_RST = 7'd24;

    // One word of the block table.
    typedef struct packed {
        logic              free;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
    } t_entry;

endpackage

>>> design/ffsa_ram.sv
`timescale 1ns / 1ps

module ffsa_ram #(
    parameter int WIDTH = 43,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/first_fit_stack_allocator_core.sv
`timescale 1ns / 1ps

// Channel    Direction  Handshake                    Payload
// command    in         start & !busy                i_command, i_req_size, i_address
// result     out        o_done (one-cycle strobe)    o_address_res, o_status,
//                                                    o_block_count, o_break_offset
// config     in         i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
//
// One command is worked on at a time; busy is high from the transfer through the result
// strobe. The block table lives in one RAM with a registered read, scanned from the top one
// entry per cycle. An allocate takes the first fitting free block, else pushes a new one or
// reports out of space; a free marks its block free and pops free blocks off the top, or
// reports an unknown address; a null free goes straight to the result. Reset clears the
// count, the break and the control state but not the RAM. The receiver cannot stall results.
module first_fit_stack_allocator_core #(
    parameter int MAX_BLOCKS  = 64,
    parameter int ARENA_BYTES = 1048576
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_command,
    input  logic [ffsa_pkg::ADDR_W-1:0]        i_req_size,
    input  logic [ffsa_pkg::ADDR_W-1:0]        i_address,
    output logic                               o_done,
    output logic [ffsa_pkg::ADDR_W-1:0]        o_address_res,
    output logic [ffsa_pkg::STATUS_W-1:0]      o_status,
    output logic [ffsa_pkg::COUNT_W-1:0]       o_block_count,
    output logic [ffsa_pkg::ADDR_W-1:0]        o_break_offset,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ffsa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ffsa_pkg::ADDR_W-1:0]        i_cfg_data
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = $bits(ffsa_pkg::t_entry);
    localparam int A  = ffsa_pkg::ADDR_W;

    // Controller states. The scan state serves both the search and the pop
    // of free blocks after a free; r_pop tells which.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0]                     r_state, n_state;
    logic                           r_pop, n_pop;
    logic [CW-1:0]                  r_issue, n_issue;
    logic                           r_pend, n_pend;
    logic [AW-1:0]                  r_pend_idx, n_pend_idx;
    logic [CW-1:0]                  r_count, n_count;
    logic [A-1:0]                   r_brk, n_brk;
    logic [A-1:0]                   r_arena_limit;
    logic [ffsa_pkg::HDR_W-1:0]     r_hdr;

    logic                           r_cmd, n_cmd;
    logic [A-1:0]                   r_req, n_req;
    logic [A-1:0]                   r_addr, n_addr;
    logic [A-1:0]                   r_res_addr, n_res_addr;
    logic [ffsa_pkg::STATUS_W-1:0]  r_status, n_status;

    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    ffsa_pkg::t_entry               mem_wdata;
    logic [AW-1:0]                  mem_raddr;
    logic [EW-1:0]                  mem_rdata;
    ffsa_pkg::t_entry               rd;

    logic [CW-1:0]                  issue_m1;
    logic                           hit;
    logic [A:0]                     top_end;
    logic [A:0]                     push_base;
    logic [A+1:0]                   push_end;
    logic [31:0]                    eff_limit;
    logic                           push_fail;

    ffsa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd        = ffsa_pkg::t_entry'(mem_rdata);
    assign issue_m1  = r_issue - CW'(1);
    assign mem_raddr = issue_m1[AW-1:0];

    // A pending entry stops the walk: in the search a fitting free block
    // (allocate) or a matching data address (free), in the pop a used block.
    always_comb begin
        if (!r_pend) begin
            hit = 1'b0;
        end else if (r_pop) begin
            hit = !rd.free;
        end else if (r_cmd == ffsa_pkg::CMD_ALLOC) begin
            hit = rd.free && (rd.size >= r_req);
        end else begin
            hit = (rd.base == r_addr);
        end
    end

    assign top_end   = {1'b0, rd.base} + {1'b0, rd.size};
    assign push_base = {1'b0, r_brk} + (A + 1)'(r_hdr);
    assign push_end  = {1'b0, push_base} + {2'b00, r_req};
    assign eff_limit = ({11'd0, r_arena_limit} < 32'(ARENA_BYTES)) ?
                       {11'd0, r_arena_limit} : 32'(ARENA_BYTES);
    assign push_fail = (r_count >= CW'(MAX_BLOCKS)) ||
                       ({{(32 - A - 2){1'b0}}, push_end} > eff_limit);

    always_comb begin
        n_state    = r_state;
        n_pop      = r_pop;
        n_issue    = r_issue;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_count    = r_count;
        n_brk      = r_brk;
        n_cmd      = r_cmd;
        n_req      = r_req;
        n_addr     = r_addr;
        n_res_addr = r_res_addr;
        n_status   = r_status;
        mem_we     = 1'b0;
        mem_waddr  = r_pend_idx;
        mem_wdata  = rd;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd      = i_command;
                    n_req      = i_req_size;
                    n_addr     = i_address;
                    n_issue    = r_count;
                    n_pend     = 1'b0;
                    n_pop      = 1'b0;
                    n_res_addr = '0;
                    n_status   = ffsa_pkg::ST_OK;
                    if (i_command == ffsa_pkg::CMD_FREE && i_address == '0) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Keep one read in flight, walking down from the top.
                if (r_issue != '0) begin
                    n_issue    = issue_m1;
                    n_pend     = 1'b1;
                    n_pend_idx = issue_m1[AW-1:0];
                end else begin
                    n_pend = 1'b0;
                end

                if (r_pop) begin
                    if (hit) begin
                        n_brk   = top_end[A-1:0];
                        n_state = S_RESP;
                    end else if (r_pend) begin
                        n_count = CW'(r_pend_idx);
                    end else if (r_issue == '0) begin
                        n_count = '0;
                        n_brk   = '0;
                        n_state = S_RESP;
                    end
                end else begin
                    if (hit) begin
                        mem_we    = 1'b1;
                        mem_wdata = '{free: r_cmd, base: rd.base, size: rd.size};
                        if (r_cmd == ffsa_pkg::CMD_ALLOC) begin
                            n_res_addr = rd.base;
                            n_state    = S_RESP;
                        end else begin
                            // Restart the walk from the top once the write
                            // has landed, so the pop sees the new flag.
                            n_pop   = 1'b1;
                            n_issue = r_count;
                            n_pend  = 1'b0;
                        end
                    end else if (!r_pend && r_issue == '0) begin
                        if (r_cmd == ffsa_pkg::CMD_ALLOC) begin
                            n_state = S_PUSH;
                        end else begin
                            n_status = ffsa_pkg::ST_UNKNOWN_ADDR;
                            n_state  = S_RESP;
                        end
                    end
                end
            end
            S_PUSH: begin
                mem_waddr = r_count[AW-1:0];
                if (push_fail) begin
                    n_status = ffsa_pkg::ST_OUT_OF_SPACE;
                end else begin
                    mem_we     = 1'b1;
                    mem_wdata  = '{free: 1'b0, base: push_base[A-1:0], size: r_req};
                    n_count    = r_count + CW'(1);
                    n_brk      = push_end[A-1:0];
                    n_res_addr = push_base[A-1:0];
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pop         <= 1'b0;
            r_issue       <= '0;
            r_pend        <= 1'b0;
            r_count       <= '0;
            r_brk         <= '0;
            r_arena_limit <= ffsa_pkg::ARENA_LIMIT_RST;
            r_hdr         <= ffsa_pkg::HEADER_BYTES_RST;
        end else begin
            r_state <= n_state;
            r_pop   <= n_pop;
            r_issue <= n_issue;
            r_pend  <= n_pend;
            r_count <= n_count;
            r_brk   <= n_brk;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ffsa_pkg::CFG_ARENA_LIMIT:  r_arena_limit <= i_cfg_data;
                    ffsa_pkg::CFG_HEADER_BYTES: r_hdr <= i_cfg_data[ffsa_pkg::HDR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_cmd      <= n_cmd;
        r_req      <= n_req;
        r_addr     <= n_addr;
        r_res_addr <= n_res_addr;
        r_status   <= n_status;
    end

    // The result is shown for the single cycle spent in the response state,
    // so the count and break already reflect this command.
    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_done         = (r_state == S_RESP);
    assign o_address_res  = r_res_addr;
    assign o_status       = r_status;
    assign o_block_count  = ffsa_pkg::COUNT_W'(r_count);
    assign o_break_offset = r_brk;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not make the block busy");

    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ffsa_pkg::ST_OK) |-> (o_address_res == '0))
        else $error("failed command returned a nonzero address");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BLOCKS))
        else $error("block count beyond table depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH && mem_we) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the stack by one");

endmodule
